// ===== design/chunky_to_planar_converter_assert.svh =====
// ---------------------------------------------------------------------------
// chunky_to_planar_converter_assert.svh
// assertion macros shared by the c2p_ctrl and c2p_merge modules
// ---------------------------------------------------------------------------
`ifndef CHUNKY_TO_PLANAR_CONVERTER_ASSERT_SVH
`define CHUNKY_TO_PLANAR_CONVERTER_ASSERT_SVH

// condition must hold on every clock out of reset
`define C2P_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence in the same cycle
`define C2P_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the following cycle
`define C2P_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/c2p_pkg.sv =====
// ---------------------------------------------------------------------------
// c2p_pkg
// shared types and constants of the chunky to planar converter
// ---------------------------------------------------------------------------
package c2p_pkg;

    localparam int PIXEL_W          = 8;
    localparam int PIXELS_PER_GROUP = 8;
    localparam int OFFSET_W         = 20;
    localparam int PLANE_NUM_W      = 3;
    localparam int GROUPS_REG_W     = 8;
    localparam int ROWS_REG_W       = 11;
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 11;

    // register reset values
    localparam logic [GROUPS_REG_W-1:0] GROUPS_RESET = 8'd40;
    localparam logic [ROWS_REG_W-1:0]   ROWS_RESET   = 11'd200;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GROUPS_PER_ROW = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_ROWS     = 1'd1;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef pixel_t [PIXELS_PER_GROUP-1:0] pixel_group_t;

    // one plane byte with its place in the body
    typedef struct packed {
        logic [PIXEL_W-1:0]  plane_byte;
        logic [OFFSET_W-1:0] body_offset;
    } lane_result_t;

    // status of the lane stage toward the merge stage
    typedef struct packed {
        logic valid;
        logic image_end;
    } stage_status_t;

endpackage

// ===== design/c2p_lane.sv =====
// ---------------------------------------------------------------------------
// c2p_lane
// one bitplane lane: gathers plane bit of each pixel and computes its offset
// ---------------------------------------------------------------------------
module c2p_lane #(
    parameter int PLANE = 0,
    parameter int GW    = 8
) (
    input  logic                  clk,
    input  logic                  load,
    input  c2p_pkg::pixel_group_t pixels,
    input  logic [GW-1:0]         groups_eff,
    input  logic [GW-1:0]         group_cnt,
    input  logic [c2p_pkg::OFFSET_W-1:0] row_base,
    output c2p_pkg::lane_result_t result
);

    logic [c2p_pkg::PIXEL_W-1:0]  bits_next;
    logic [c2p_pkg::OFFSET_W-1:0] offset_next;
    c2p_pkg::lane_result_t        result_reg;

    // leftmost pixel lands in the msb
    always_comb
    begin
        for (int i = 0; i < c2p_pkg::PIXELS_PER_GROUP; i++)
        begin
            bits_next[c2p_pkg::PIXELS_PER_GROUP-1-i] = pixels[i][PLANE];
        end
    end

    // row base + plane * groups + group, wraps at the offset width
    assign offset_next = c2p_pkg::OFFSET_W'(32'(row_base)
                                            + 32'(PLANE) * 32'(groups_eff)
                                            + 32'(group_cnt));

    // lane result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.plane_byte  <= bits_next;
            result_reg.body_offset <= offset_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== design/c2p_ctrl.sv =====
// ---------------------------------------------------------------------------
// c2p_ctrl
// size registers, group and row counters, lane stage occupancy
// ---------------------------------------------------------------------------
`include "chunky_to_planar_converter_assert.svh"

module c2p_ctrl #(
    parameter int MAX_GROUPS  = 128,
    parameter int MAX_ROWS    = 1024,
    parameter int PLANE_COUNT = 8,
    parameter int GW          = 8,
    parameter int RW          = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [c2p_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [c2p_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              take,
    output logic                              load,
    output logic [GW-1:0]                     groups_eff,
    output logic [GW-1:0]                     group_cnt,
    output logic [c2p_pkg::OFFSET_W-1:0]      row_base,
    output c2p_pkg::stage_status_t            status
);

    logic [c2p_pkg::GROUPS_REG_W-1:0] groups_reg;
    logic [c2p_pkg::ROWS_REG_W-1:0]   rows_reg;
    logic [GW-1:0]                    group_reg, group_next;
    logic [RW-1:0]                    row_reg, row_next;
    logic [c2p_pkg::OFFSET_W-1:0]     base_reg, base_next;
    logic                             a_valid_reg, a_valid_next;
    logic                             a_end_reg;
    logic [31:0]                      g32, r32;
    logic [RW-1:0]                    rows_eff;
    logic                             last_group, last_row, image_end;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg <= c2p_pkg::GROUPS_RESET;
            rows_reg   <= c2p_pkg::ROWS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                c2p_pkg::REG_GROUPS_PER_ROW: groups_reg <= cfg_data[c2p_pkg::GROUPS_REG_W-1:0];
                c2p_pkg::REG_IMAGE_ROWS:     rows_reg   <= cfg_data[c2p_pkg::ROWS_REG_W-1:0];
                default:                     ;
            endcase
        end
    end

    // zero counts as one, oversize counts as the maximum
    always_comb
    begin
        g32 = 32'(groups_reg);
        if (groups_reg == '0)
            g32 = 32'd1;
        else if (g32 > 32'(MAX_GROUPS))
            g32 = 32'(MAX_GROUPS);
        r32 = 32'(rows_reg);
        if (rows_reg == '0)
            r32 = 32'd1;
        else if (r32 > 32'(MAX_ROWS))
            r32 = 32'(MAX_ROWS);
    end

    assign groups_eff = g32[GW-1:0];
    assign rows_eff   = r32[RW-1:0];

    // wrap tests are at or beyond the last position
    assign last_group = (32'(group_reg) + 32'd1) >= 32'(groups_eff);
    assign last_row   = (32'(row_reg) + 32'd1) >= 32'(rows_eff);
    assign image_end  = last_group && last_row;

    // lane stage handshake
    assign in_stall = a_valid_reg && !take;
    assign load     = in_valid && !in_stall;

    // counter advance per accepted group
    always_comb
    begin
        group_next   = group_reg;
        row_next     = row_reg;
        base_next    = base_reg;
        a_valid_next = a_valid_reg;
        if (take)
            a_valid_next = 1'b0;
        if (load)
        begin
            a_valid_next = 1'b1;
            if (last_group)
            begin
                group_next = '0;
                if (last_row)
                begin
                    row_next  = '0;
                    base_next = '0;
                end
                else
                begin
                    row_next  = row_reg + RW'(1);
                    base_next = c2p_pkg::OFFSET_W'(32'(base_reg)
                                + 32'(PLANE_COUNT) * 32'(groups_eff));
                end
            end
            else
            begin
                group_next = group_reg + GW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg   <= '0;
            row_reg     <= '0;
            base_reg    <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            group_reg   <= group_next;
            row_reg     <= row_next;
            base_reg    <= base_next;
            a_valid_reg <= a_valid_next;
        end
    end

    // end flag travels with the lane results
    always_ff @(posedge clk)
    begin
        if (load)
            a_end_reg <= image_end;
    end

    assign group_cnt        = group_reg;
    assign row_base         = base_reg;
    assign status.valid     = a_valid_reg;
    assign status.image_end = a_end_reg;

    `C2P_ASSERT_ALWAYS(a_group_range, clk, rst_n, group_reg < GW'(MAX_GROUPS), "group counter out of range")
    `C2P_ASSERT_ALWAYS(a_row_range, clk, rst_n, row_reg < RW'(MAX_ROWS), "row counter out of range")
    `C2P_ASSERT_NEXT(a_load_fills, clk, rst_n, load, a_valid_reg, "lane stage not filled after request")

endmodule

// ===== design/c2p_merge.sv =====
// ---------------------------------------------------------------------------
// c2p_merge
// collects the lane results and sends them out one plane byte per cycle while out_stall is low
// ---------------------------------------------------------------------------
`include "chunky_to_planar_converter_assert.svh"

module c2p_merge #(
    parameter int PLANE_COUNT = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  c2p_pkg::stage_status_t                status,
    input  c2p_pkg::lane_result_t                 lanes [PLANE_COUNT],
    output logic                                  take,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [c2p_pkg::PIXEL_W-1:0]           plane_byte,
    output logic [c2p_pkg::OFFSET_W-1:0]          body_offset,
    output logic [c2p_pkg::PLANE_NUM_W-1:0]       plane_number,
    output logic                                  last_of_group,
    output logic                                  end_of_image
);

    localparam int IW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    c2p_pkg::lane_result_t bank_reg [PLANE_COUNT];
    logic [IW-1:0]         idx_reg;
    logic                  b_valid_reg;
    logic                  b_end_reg;
    logic                  out_take;
    logic                  last;

    assign last     = idx_reg == IW'(PLANE_COUNT - 1);
    assign out_take = b_valid_reg && !out_stall;
    assign take     = status.valid && (!b_valid_reg || (out_take && last));

    // control of the output bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            b_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg     <= '0;
            b_valid_reg <= 1'b1;
        end
        else if (out_take && last)
        begin
            idx_reg     <= '0;
            b_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    // bank loads from the lanes, then shifts toward entry zero
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
                bank_reg[i] <= lanes[i];
            b_end_reg <= status.image_end;
        end
        else if (out_take)
        begin
            for (int i = 0; i < PLANE_COUNT - 1; i++)
                bank_reg[i] <= bank_reg[i+1];
        end
    end

    assign out_valid     = b_valid_reg;
    assign plane_byte    = bank_reg[0].plane_byte;
    assign body_offset   = bank_reg[0].body_offset;
    assign plane_number  = c2p_pkg::PLANE_NUM_W'(idx_reg);
    assign last_of_group = last;
    assign end_of_image  = last && b_end_reg;

    `C2P_ASSERT_NEXT(a_take_starts, clk, rst_n, take, b_valid_reg && idx_reg == '0, "bank not restarted after load")
    `C2P_ASSERT_NEXT(a_plane_step, clk, rst_n, out_take && !last, out_valid && plane_number == $past(plane_number) + 3'd1, "plane number did not step")
    `C2P_ASSERT_IMPLY(a_end_last, clk, rst_n, out_valid && end_of_image, last_of_group, "image end off the last plane")

endmodule

// ===== design/chunky_to_planar_converter.sv =====
// ---------------------------------------------------------------------------
// chunky_to_planar_converter
// turns groups of eight chunky pixels into interleaved bitplane bytes
//
//   channel  handshake            payload
//   in       in_valid / in_stall  pixel_0 .. pixel_7
//   out      out_valid/out_stall  plane_byte, body_offset, plane_number,
//                                 last_of_group, end_of_image
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// the output bank sends a group's plane bytes on the one-byte output, one
// plane byte per cycle while out_stall is low; lanes compute all planes
// at once, and the next group enters the bank as its last byte leaves.
// first byte passes the lane result register and then the output bank.
// reset clears counters, stage flags and sets the size registers to 40 x 200.
// a stalled output holds its byte; one more group waits in the lane stage.
// ---------------------------------------------------------------------------
module chunky_to_planar_converter #(
    parameter int MAX_GROUPS  = 128,
    parameter int MAX_ROWS    = 1024,
    parameter int PLANE_COUNT = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [c2p_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [c2p_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [c2p_pkg::PIXEL_W-1:0]         pixel_0,
    input  logic [c2p_pkg::PIXEL_W-1:0]         pixel_1,
    input  logic [c2p_pkg::PIXEL_W-1:0]         pixel_2,
    input  logic [c2p_pkg::PIXEL_W-1:0]         pixel_3,
    input  logic [c2p_pkg::PIXEL_W-1:0]         pixel_4,
    input  logic [c2p_pkg::PIXEL_W-1:0]         pixel_5,
    input  logic [c2p_pkg::PIXEL_W-1:0]         pixel_6,
    input  logic [c2p_pkg::PIXEL_W-1:0]         pixel_7,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [c2p_pkg::PIXEL_W-1:0]         plane_byte,
    output logic [c2p_pkg::OFFSET_W-1:0]        body_offset,
    output logic [c2p_pkg::PLANE_NUM_W-1:0]     plane_number,
    output logic                                last_of_group,
    output logic                                end_of_image
);

    localparam int GW = $clog2(MAX_GROUPS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    c2p_pkg::pixel_group_t         pixels;
    c2p_pkg::lane_result_t         lanes [PLANE_COUNT];
    c2p_pkg::stage_status_t        status;
    logic                          load;
    logic                          take;
    logic [GW-1:0]                 groups_eff;
    logic [GW-1:0]                 group_cnt;
    logic [c2p_pkg::OFFSET_W-1:0]  row_base;

    // pixel group, leftmost first
    assign pixels[0] = pixel_0;
    assign pixels[1] = pixel_1;
    assign pixels[2] = pixel_2;
    assign pixels[3] = pixel_3;
    assign pixels[4] = pixel_4;
    assign pixels[5] = pixel_5;
    assign pixels[6] = pixel_6;
    assign pixels[7] = pixel_7;

    // counters, sizes and lane stage control
    c2p_ctrl #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_ROWS    (MAX_ROWS),
        .PLANE_COUNT (PLANE_COUNT),
        .GW          (GW),
        .RW          (RW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .take       (take),
        .load       (load),
        .groups_eff (groups_eff),
        .group_cnt  (group_cnt),
        .row_base   (row_base),
        .status     (status)
    );

    // one lane per bitplane
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_lane
        c2p_lane #(
            .PLANE (p),
            .GW    (GW)
        ) u_lane (
            .clk        (clk),
            .load       (load),
            .pixels     (pixels),
            .groups_eff (groups_eff),
            .group_cnt  (group_cnt),
            .row_base   (row_base),
            .result     (lanes[p])
        );
    end

    // serialize plane bytes
    c2p_merge #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .status        (status),
        .lanes         (lanes),
        .take          (take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .plane_byte    (plane_byte),
        .body_offset   (body_offset),
        .plane_number  (plane_number),
        .last_of_group (last_of_group),
        .end_of_image  (end_of_image)
    );

endmodule
